/* hdl/ptpp_pkg.sv */
// Shared types, constants and line table for the printer test pattern pixel block.
`timescale 1ns / 1ps
`default_nettype none

package ptpp_pkg;

  // Field and register widths
  localparam int unsigned COL_W  = 12;
  localparam int unsigned ROW_W  = 9;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // Register map, indexed by paddr[2]
  localparam logic REG_WIDTH_DOTS = 1'b0;

  localparam logic [COL_W-1:0] WIDTH_RESET = 12'd384;
  localparam logic [ROW_W-1:0] PATTERN_HEIGHT = 9'd420;

  // Fine line groups: 4 widths, 8 lines each
  localparam int unsigned FINE_GROUPS = 4;
  localparam int unsigned FINE_PER_GROUP = 8;
  localparam int unsigned FINE_LINES = FINE_GROUPS * FINE_PER_GROUP;
  localparam int unsigned FINE_IDX_W = $clog2(FINE_LINES);
  localparam int unsigned FINE_POS_W = 8;

  // Row regions of the pattern
  typedef enum logic [3:0] {
    REG_WHITE      = 4'd0,
    REG_SOLID      = 4'd1,
    REG_TICK       = 4'd2,
    REG_VBAR       = 4'd3,
    REG_HBAR       = 4'd4,
    REG_CHECK      = 4'd5,
    REG_FINE       = 4'd6,
    REG_FRAME_SIDE = 4'd7
  } region_t;

  // Per-region black terms, valid in the second stage
  typedef struct packed {
    logic tick;
    logic vbar;
    logic hbar;
    logic check;
    logic fine;
    logic frame;
  } terms_t;

  // Left column of fine line idx; cursor runs 8, then +2n per line, +12 per group
  function automatic logic [FINE_POS_W-1:0] fine_start(input logic [FINE_IDX_W-1:0] idx);
    logic [1:0] grp;
    logic [2:0] k;
    logic [FINE_POS_W-1:0] base;
    logic [FINE_POS_W-1:0] step;
    grp = idx[FINE_IDX_W-1:FINE_IDX_W-2];
    k   = idx[2:0];
    unique case (grp)
      2'd0:    base = 8'd8;
      2'd1:    base = 8'd36;
      2'd2:    base = 8'd80;
      default: base = 8'd140;
    endcase
    step = {5'd0, grp} + 8'd1;
    return base + 8'({k, 1'b0} * step);
  endfunction

  // Width in dots of fine line idx
  function automatic logic [FINE_POS_W-1:0] fine_width(input logic [FINE_IDX_W-1:0] idx);
    return {6'd0, idx[FINE_IDX_W-1:FINE_IDX_W-2]} + 8'd1;
  endfunction

endpackage

`default_nettype wire

/* hdl/printer_test_pattern_pixel.sv */
// Top level: three-stage pixel pipeline for the thermal-printer test pattern.
// A pixel passes the stage A, stage B and output registers before it shows on out_*.
// Throughput: one pixel per clock; busy stays low, the pipeline never holds an item.
// The receiver cannot stall: each result strobes out_valid for exactly one cycle.
// Reset (rst_n low, synchronous) drops all in-flight pixels and sets width_dots to 384.
// Stages: bounds and row-region decode, fine line compares and other terms, final select.
`timescale 1ns / 1ps
`default_nettype none

module printer_test_pattern_pixel
  import ptpp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Pixel command channel
  input  wire logic              start,
  output      logic              busy,
  input  wire logic [COL_W-1:0]  in_col,
  input  wire logic [ROW_W-1:0]  in_row,
  // Result channel
  output      logic              out_valid,
  output      logic              out_black,
  output      logic              out_in_image,
  // Configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output      logic [DATA_W-1:0] prdata,
  output      logic              pready
);

  logic             in_xfer;
  logic [COL_W-1:0] width_r;

  // Stage A registers
  logic             a_valid_r;
  logic [COL_W-1:0] a_col_r;
  logic             a_in_image_r,  a_in_image_nxt;
  region_t          a_region_r,    a_region_nxt;
  logic             a_short_r,     a_short_nxt;
  logic             a_row0_r;

  // Stage B registers
  logic             b_valid_r;
  logic             b_in_image_r;
  region_t          b_region_r;
  terms_t           b_terms_r,     b_terms_nxt;

  // Output registers
  logic             out_valid_r;
  logic             out_black_r,   out_black_nxt;
  logic             out_in_image_r;

  logic [FINE_LINES-1:0] fine_match;

  assign busy    = 1'b0;
  assign in_xfer = start & ~busy;
  assign pready  = 1'b1;

  // Configuration register write and read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_WIDTH_DOTS) begin
      width_r <= pwdata[COL_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_WIDTH_DOTS) ? {{(DATA_W-COL_W){1'b0}}, width_r} : '0;

  // Stage A: bounds check and row region decode
  always_comb begin
    a_in_image_nxt = (in_col < width_r) && (in_row < PATTERN_HEIGHT);
    a_short_nxt    = in_row < 9'd26;
    priority if (in_row < 9'd8) begin
      a_region_nxt = REG_SOLID;
    end else if (in_row >= 9'd12 && in_row < 9'd36) begin
      a_region_nxt = REG_TICK;
    end else if (in_row >= 9'd48 && in_row < 9'd72) begin
      a_region_nxt = REG_SOLID;
    end else if (in_row >= 9'd80 && in_row < 9'd104) begin
      a_region_nxt = REG_VBAR;
    end else if (in_row >= 9'd112 && in_row < 9'd136) begin
      a_region_nxt = REG_HBAR;
    end else if (in_row >= 9'd144 && in_row < 9'd168) begin
      a_region_nxt = REG_CHECK;
    end else if (in_row >= 9'd176 && in_row < 9'd208) begin
      a_region_nxt = REG_FINE;
    end else if (in_row >= 9'd224 && in_row < 9'd228) begin
      a_region_nxt = REG_SOLID;
    end else if (in_row >= 9'd228 && in_row < 9'd284) begin
      a_region_nxt = REG_FRAME_SIDE;
    end else if (in_row >= 9'd284 && in_row < 9'd288) begin
      a_region_nxt = REG_SOLID;
    end else begin
      a_region_nxt = REG_WHITE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    a_col_r      <= in_col;
    a_in_image_r <= a_in_image_nxt;
    a_region_r   <= a_region_nxt;
    a_short_r    <= a_short_nxt;
    a_row0_r     <= in_row[0];
  end

  // Stage B: fine line hits, frame edge, bar, check and tick terms
  always_comb begin
    for (int j = 0; j < FINE_LINES; j++) begin
      fine_match[j] =
        ({1'b0, a_col_r} >= {5'd0, fine_start(FINE_IDX_W'(j))}) &&
        ({1'b0, a_col_r} <  {5'd0, fine_start(FINE_IDX_W'(j))}
                            + {5'd0, fine_width(FINE_IDX_W'(j))}) &&
        ({5'd0, fine_start(FINE_IDX_W'(j))} + 13'd8 < {1'b0, width_r});
    end
    b_terms_nxt.fine  = |fine_match;
    b_terms_nxt.frame = (a_col_r < 12'd4) ||
                        ({1'b0, a_col_r} + 13'd4 >= {1'b0, width_r});
    b_terms_nxt.tick  = (a_col_r[5:0] < 6'd2) && (!a_col_r[6] || a_short_r);
    b_terms_nxt.vbar  = ~a_col_r[0];
    b_terms_nxt.hbar  = ~a_row0_r;
    b_terms_nxt.check = a_col_r[0] ^ a_row0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    b_in_image_r <= a_in_image_r;
    b_region_r   <= a_region_r;
    b_terms_r    <= b_terms_nxt;
  end

  // Stage C: select the term for the row region, mask outside the image
  always_comb begin
    unique case (b_region_r)
      REG_SOLID:      out_black_nxt = 1'b1;
      REG_TICK:       out_black_nxt = b_terms_r.tick;
      REG_VBAR:       out_black_nxt = b_terms_r.vbar;
      REG_HBAR:       out_black_nxt = b_terms_r.hbar;
      REG_CHECK:      out_black_nxt = b_terms_r.check;
      REG_FINE:       out_black_nxt = b_terms_r.fine;
      REG_FRAME_SIDE: out_black_nxt = b_terms_r.frame;
      default:        out_black_nxt = 1'b0;
    endcase
    out_black_nxt = out_black_nxt & b_in_image_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_black_r    <= out_black_nxt;
    out_in_image_r <= b_in_image_r;
  end

  assign out_valid    = out_valid_r;
  assign out_black    = out_black_r;
  assign out_in_image = out_in_image_r;

  // Each transferred pixel yields one strobe after the stage A, stage B and output registers
  a_latency: assert property (@(posedge clk)
    (rst_n && $past(rst_n) && $past(rst_n, 2) && $past(rst_n, 3))
      |-> (out_valid == $past(in_xfer, 3)))
    else $error("result strobe does not follow pixel transfer by three cycles");

  // A dot outside the image is never black
  a_white_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_image) |-> !out_black)
    else $error("black dot reported outside the image");

  // The bounds flag carried to stage B matches the column of stage A
  a_bounds_carry: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && b_in_image_r && $past(rst_n)) |-> ($past(a_col_r) < $past(width_r)))
    else $error("in-image flag disagrees with column and width");

  // A black dot in the fine line rows needs a fine line hit
  a_fine_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_black && $past(b_region_r) == REG_FINE) |-> $past(b_terms_r.fine))
    else $error("fine line region reported black without a line hit");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Testbench for the printer test pattern pixel block: random and directed pixels, scoreboard.
`timescale 1ns / 1ps

// Expected-dot store and pattern predictor for the test pattern pixel block
class pattern_scoreboard;
  typedef struct packed {
    bit black;
    bit in_image;
  } dot_t;

  dot_t expected_q[$];
  int   width_dots;
  int   errors;

  function new();
    width_dots = int'(ptpp_pkg::WIDTH_RESET);
    errors     = 0;
  endfunction

  function void set_width(int w);
    width_dots = w;
  endfunction

  // Walk the fine line cursor: widths 1..4, eight lines each, stop near the right edge
  function bit fine_line(int c, int w);
    int pos;
    pos = 8;
    for (int n = 1; n <= 4; n++) begin
      for (int k = 0; k < 8; k++) begin
        if (pos + 8 >= w) return 1'b0;
        if (c >= pos && c < pos + n) return 1'b1;
        pos += 2 * n;
      end
      pos += 12;
    end
    return 1'b0;
  endfunction

  function bit dot_black(int c, int r, int w);
    if (r < 8) return 1'b1;
    if (r >= 12 && r < 36 && (c % 64) < 2) return ((c / 64) % 2 == 0) || r < 26;
    if (r >= 48 && r < 72) return 1'b1;
    if (r >= 80 && r < 104) return (c % 2) == 0;
    if (r >= 112 && r < 136) return (r % 2) == 0;
    if (r >= 144 && r < 168) return ((c + r) % 2) == 1;
    if (r >= 176 && r < 208) return fine_line(c, w);
    if (r >= 224 && r < 228) return 1'b1;
    if (r >= 228 && r < 284) return c < 4 || c >= w - 4;
    if (r >= 284 && r < 288) return 1'b1;
    return 1'b0;
  endfunction

  // Note one accepted pixel transfer and queue its expected dot
  function void note_pixel(logic [ptpp_pkg::COL_W-1:0] col, logic [ptpp_pkg::ROW_W-1:0] row);
    dot_t d;
    int   c;
    int   r;
    c = int'(col);
    r = int'(row);
    if (c >= width_dots || r >= int'(ptpp_pkg::PATTERN_HEIGHT)) begin
      d.black    = 1'b0;
      d.in_image = 1'b0;
    end else begin
      d.black    = dot_black(c, r, width_dots);
      d.in_image = 1'b1;
    end
    expected_q.push_back(d);
  endfunction

  // Compare one result transfer with the oldest expected dot
  function void check_result(logic black, logic in_image);
    dot_t d;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result black=%b in_image=%b", $time, black, in_image);
      errors++;
      return;
    end
    d = expected_q.pop_front();
    if (black !== d.black) begin
      $display("%0t: black mismatch, expected %b, actual %b", $time, d.black, black);
      errors++;
    end
    if (in_image !== d.in_image) begin
      $display("%0t: in_image mismatch, expected %b, actual %b", $time, d.in_image, in_image);
      errors++;
    end
  endfunction
endclass

module testbench;
  import ptpp_pkg::*;

  localparam logic [ADDR_W-1:0] WIDTH_ADDR = {REG_WIDTH_DOTS, 2'b00};
  localparam int IDLE_PCT = 34;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [COL_W-1:0]  in_col = '0;
  logic [ROW_W-1:0]  in_row = '0;
  logic              out_valid;
  logic              out_black;
  logic              out_in_image;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  pattern_scoreboard dots;

  printer_test_pattern_pixel dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_col       (in_col),
    .in_row       (in_row),
    .out_valid    (out_valid),
    .out_black    (out_black),
    .out_in_image (out_in_image),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both channels at the rising edge: note pixel transfers, check result transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) dots.note_pixel(in_col, in_row);
      if (out_valid) dots.check_result(out_black, out_in_image);
    end
  end

  // Drive one pixel, after a random run of idle cycles unless held steady
  task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                            input bit steady);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
      end
    end
    @(negedge clk);
    start  <= 1'b1;
    in_col <= col;
    in_row <= row;
    do @(posedge clk); while (busy);
  endtask

  // Hold off the sender until every expected dot has come back
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (dots.expected_q.size() != 0) @(posedge clk);
  endtask

  // Write width_dots over the configuration port, then read it back
  task automatic write_width(input int unsigned w);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WIDTH_ADDR;
    pwdata  <= DATA_W'(w);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    dots.set_width(int'(w));
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[COL_W-1:0] !== COL_W'(w)) begin
      $display("%0t: width_dots readback mismatch, expected %0d, actual %0d",
               $time, w, prdata[COL_W-1:0]);
      dots.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly in-image columns, some around the right edge, some anywhere
  function automatic logic [COL_W-1:0] pick_col(input int w);
    int sel;
    int v;
    sel = $urandom_range(0, 99);
    if (w > 0 && sel < 60) return COL_W'($urandom_range(0, w - 1));
    if (sel < 80) begin
      v = w - 6 + int'($urandom_range(0, 8));
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return COL_W'(v);
    end
    return COL_W'($urandom_range(0, 4095));
  endfunction

  // Mostly pattern rows, some around the bottom edge, some anywhere
  function automatic logic [ROW_W-1:0] pick_row();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return ROW_W'($urandom_range(0, 299));
    if (sel < 85) return ROW_W'($urandom_range(410, 429));
    return ROW_W'($urandom_range(0, 511));
  endfunction

  task automatic run_phase(input int unsigned w, input int n_items, input bit steady);
    drain_results();
    write_width(w);
    for (int i = 0; i < n_items; i++) send_pixel(pick_col(int'(w)), pick_row(), steady);
  endtask

  initial begin
    dots = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pixels at the reset width: edges, every row region, tick heights
    send_pixel(12'd0,    9'd0,   1'b0);
    send_pixel(12'd4095, 9'd0,   1'b0);
    send_pixel(12'd383,  9'd7,   1'b0);
    send_pixel(12'd384,  9'd0,   1'b0);
    send_pixel(12'd0,    9'd419, 1'b0);
    send_pixel(12'd0,    9'd420, 1'b0);
    send_pixel(12'd4095, 9'd511, 1'b0);
    send_pixel(12'd1,    9'd35,  1'b0);
    send_pixel(12'd64,   9'd25,  1'b0);
    send_pixel(12'd65,   9'd30,  1'b0);
    send_pixel(12'd2,    9'd12,  1'b0);
    send_pixel(12'd1,    9'd80,  1'b0);
    send_pixel(12'd0,    9'd103, 1'b0);
    send_pixel(12'd5,    9'd112, 1'b0);
    send_pixel(12'd5,    9'd113, 1'b0);
    send_pixel(12'd1,    9'd144, 1'b0);
    send_pixel(12'd8,    9'd176, 1'b0);
    send_pixel(12'd9,    9'd207, 1'b0);
    send_pixel(12'd36,   9'd190, 1'b0);
    send_pixel(12'd100,  9'd226, 1'b0);
    send_pixel(12'd380,  9'd250, 1'b0);
    send_pixel(12'd100,  9'd250, 1'b0);
    send_pixel(12'd3,    9'd283, 1'b0);
    send_pixel(12'd100,  9'd300, 1'b0);

    // Random pixels over a sweep of head widths, extremes included
    run_phase(384, 100, 1'b0);
    run_phase(4095, 200, 1'b1);
    run_phase(1, 60, 1'b0);
    run_phase(4, 60, 1'b0);
    run_phase(5, 60, 1'b0);
    run_phase(0, 40, 1'b0);
    run_phase(17, 80, 1'b0);
    run_phase(64, 100, 1'b0);
    run_phase($urandom_range(6, 500), 150, 1'b0);
    run_phase($urandom_range(1, 4095), 100, 1'b0);
    run_phase(300, 150, 1'b0);

    // Let the pipeline empty, then allow for its latency
    drain_results();
    repeat (8) @(posedge clk);
    if (dots.errors == 0 && dots.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

/* files.f */
hdl/ptpp_pkg.sv
hdl/printer_test_pattern_pixel.sv
tb/testbench.sv
